// ===== hdl/psm_pkg.sv =====
// types and constants shared by the proximity stall safety monitor files
package psm_pkg;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_EMERGENCY = 2'd3;

    // machine state codes
    localparam logic [1:0] MS_SWINGING  = 2'd1;
    localparam logic [1:0] MS_ERROR     = 2'd2;
    localparam logic [1:0] MS_EMERGENCY = 2'd3;

    // request kinds
    localparam logic KIND_MOTOR = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WARNING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_WARNING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT   = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [31:0] time_ms;
        logic [15:0] left_distance_mm;
        logic [15:0] right_distance_mm;
        logic [1:0]  machine_state;
        logic        user_present;
        logic        motor_running;
        logic [15:0] motor_speed;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       raise_emergency;
        logic       raise_obstacle;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SWEEP,
        S_TAIL,
        S_FINAL
    } t_state;

endpackage

// ===== hdl/proximity_stall_safety_monitor.sv =====
// proximity and stall safety monitor top level
// operation: a request is evaluated in S_EVAL, the state after acceptance, and its response register
// loads in S_FINAL once the output register is free; a check that records an obstacle flag change first
// sweeps the change-time memory, which has a single read port, in S_SWEEP and S_TAIL
// requests: a new request is accepted only in S_IDLE, after the previous response has been loaded
// reset: synchronous active low, restores the register defaults, empties the change history
// and clears the stall counter, motor state and status
module proximity_stall_safety_monitor #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  psm_pkg::t_req                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output psm_pkg::t_rsp                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [psm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import psm_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    // configuration
    logic [15:0] r_left_warning;
    logic [15:0] r_right_warning;
    logic [15:0] r_critical;
    logic [15:0] r_change_window;
    logic [7:0]  r_change_limit;
    logic [7:0]  r_stall_limit;

    // control and state
    t_state      r_state, n_state;
    t_req        r_req;
    logic        r_hist_vld [HISTORY_DEPTH];
    logic [AW-1:0] r_slot;
    logic        r_last_flag;
    logic [15:0] r_prev_speed;
    logic [7:0]  r_stall_cnt;
    logic        r_motor_active;
    logic [1:0]  r_status;
    logic [1:0]  r_obs;
    logic        r_use_cnt;
    logic [AW-1:0] r_rd_addr;
    logic        r_pend;
    logic [AW-1:0] r_pend_addr;
    logic [CW-1:0] r_cnt;
    logic        r_out_valid;
    t_rsp        r_out;

    // change-time memory
    logic [31:0] r_mem [HISTORY_DEPTH];
    logic [31:0] r_rd_data;

    // evaluation datapath
    logic        w_swing;
    logic [19:0] w_crit10, w_warn10, w_l10, w_r10;
    logic        w_emerg, w_err, w_flag;
    logic        w_mem_we;
    logic [31:0] w_age;
    logic        w_hit;
    logic [1:0]  w_s_obs, w_s_user, w_s_motor, w_ns;
    logic        w_motor_trip;
    logic        w_raise_emerg, w_raise_obst;
    logic        w_out_free;

    assign w_swing  = (r_req.machine_state == MS_SWINGING);
    assign w_crit10 = w_swing ? 20'(r_critical) * 20'd9 : 20'(r_critical) * 20'd10;
    assign w_warn10 = w_swing ? 20'(r_left_warning) * 20'd7 : 20'(r_left_warning) * 20'd10;
    assign w_l10    = 20'(r_req.left_distance_mm) * 20'd10;
    assign w_r10    = 20'(r_req.right_distance_mm) * 20'd10;

    assign w_emerg = ((r_req.left_distance_mm != 16'd0) && (w_l10 < w_crit10)) ||
                     ((r_req.right_distance_mm != 16'd0) && (w_r10 < w_crit10));
    assign w_err   = ((w_l10 > w_crit10) && (w_l10 < w_warn10)) ||
                     ((w_r10 > w_crit10) && (w_r10 < w_warn10));
    assign w_flag  = ((r_req.left_distance_mm != 16'd0) &&
                      (r_req.left_distance_mm < r_left_warning)) ||
                     ((r_req.right_distance_mm != 16'd0) &&
                      (r_req.right_distance_mm < r_right_warning));

    assign w_mem_we = (r_state == S_EVAL) && (r_req.kind == KIND_CHECK) &&
                      !w_emerg && !w_err && (w_flag != r_last_flag);

    assign w_age = r_req.time_ms - r_rd_data;
    assign w_hit = r_pend && r_hist_vld[r_pend_addr] && (w_age < {16'd0, r_change_window});

    // final merge
    always_comb begin
        w_s_obs = r_obs;
        if (r_use_cnt) begin
            w_s_obs = (8'(r_cnt) > r_change_limit) ? ST_EMERGENCY : ST_OK;
        end
        w_s_user     = (!r_req.user_present && w_swing) ? ST_EMERGENCY : ST_OK;
        w_motor_trip = r_motor_active && (r_stall_cnt >= r_stall_limit);
        w_s_motor    = w_motor_trip ? ST_EMERGENCY : ST_OK;
        w_ns = w_s_obs;
        if (w_s_user > w_ns) begin
            w_ns = w_s_user;
        end
        if (w_s_motor > w_ns) begin
            w_ns = w_s_motor;
        end
        w_raise_emerg = 1'b0;
        w_raise_obst  = 1'b0;
        if (w_ns != r_status) begin
            if (w_ns == ST_EMERGENCY && r_req.machine_state != MS_EMERGENCY) begin
                w_raise_emerg = 1'b1;
            end else if (w_ns == ST_ERROR && r_req.machine_state != MS_ERROR &&
                         r_req.machine_state != MS_EMERGENCY) begin
                w_raise_obst = 1'b1;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = w_mem_we ? S_SWEEP : S_FINAL;
            end
            S_SWEEP: begin
                if (r_rd_addr == AW'(HISTORY_DEPTH - 1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_warning  <= 16'd1000;
            r_right_warning <= 16'd1000;
            r_critical      <= 16'd300;
            r_change_window <= 16'd3000;
            r_change_limit  <= 8'd5;
            r_stall_limit   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT_WARNING:  r_left_warning  <= i_cfg_data;
                CFG_RIGHT_WARNING: r_right_warning <= i_cfg_data;
                CFG_CRITICAL:      r_critical      <= i_cfg_data;
                CFG_CHANGE_WINDOW: r_change_window <= i_cfg_data;
                CFG_CHANGE_LIMIT:  r_change_limit  <= i_cfg_data[7:0];
                CFG_STALL_LIMIT:   r_stall_limit   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // request capture and memory read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (w_mem_we) begin
            r_mem[r_slot] <= r_req.time_ms;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist_vld[i] <= 1'b0;
            end
            r_slot         <= '0;
            r_last_flag    <= 1'b0;
            r_prev_speed   <= 16'd0;
            r_stall_cnt    <= 8'd0;
            r_motor_active <= 1'b0;
            r_status       <= ST_OK;
            r_obs          <= ST_OK;
            r_use_cnt      <= 1'b0;
            r_rd_addr      <= '0;
            r_pend         <= 1'b0;
            r_pend_addr    <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_out          <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_FINAL)) begin
                r_out_valid <= 1'b0;
            end
            if (w_hit) begin
                r_cnt <= r_cnt + CW'(1);
            end
            case (r_state)
                S_EVAL: begin
                    r_use_cnt <= 1'b0;
                    if (w_emerg) begin
                        r_obs <= ST_EMERGENCY;
                    end else if (w_err) begin
                        r_obs <= ST_ERROR;
                    end else begin
                        r_obs <= ST_OK;
                    end
                    if (w_mem_we) begin
                        // record the flag change, then count recent changes
                        r_last_flag        <= w_flag;
                        r_hist_vld[r_slot] <= 1'b1;
                        r_slot    <= (r_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + AW'(1);
                        r_use_cnt <= 1'b1;
                        r_cnt     <= '0;
                        r_rd_addr <= '0;
                    end
                end
                S_SWEEP: begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_rd_addr;
                    if (r_rd_addr != AW'(HISTORY_DEPTH - 1)) begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                    end
                end
                S_TAIL: begin
                    r_pend <= 1'b0;
                end
                S_FINAL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_req.kind == KIND_MOTOR) begin
                            r_out.status          <= r_status;
                            r_out.raise_emergency <= 1'b0;
                            r_out.raise_obstacle  <= 1'b0;
                            r_motor_active <= r_req.motor_running;
                            if (r_req.motor_running && (r_prev_speed != 16'd0) &&
                                (r_req.motor_speed == 16'd0)) begin
                                if (r_stall_cnt != 8'hff) begin
                                    r_stall_cnt <= r_stall_cnt + 8'd1;
                                end
                            end else if (r_req.motor_speed != 16'd0) begin
                                r_stall_cnt <= 8'd0;
                            end
                            r_prev_speed <= r_req.motor_speed;
                        end else begin
                            if (w_motor_trip) begin
                                r_stall_cnt <= 8'd0;
                            end
                            r_status              <= w_ns;
                            r_out.status          <= w_ns;
                            r_out.raise_emergency <= w_raise_emerg;
                            r_out.raise_obstacle  <= w_raise_obst;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/psm_checker.sv =====
// port-level checker for the proximity stall safety monitor and its bind
module psm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input psm_pkg::t_rsp                  o_out_data
);
    import psm_pkg::*;

    // a response waiting for the sink is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    a_emerg_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.raise_emergency |-> o_out_data.status == ST_EMERGENCY)
        else $error("emergency event without emergency status");

    a_obst_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.raise_obstacle |-> o_out_data.status == ST_ERROR)
        else $error("obstacle event without error status");

    // one request in flight: nothing accepted until its response is produced
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted before response");

endmodule

bind proximity_stall_safety_monitor psm_checker u_psm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== test/proximity_stall_safety_monitor_test.sv =====
// self-checking testbench for the proximity stall safety monitor
`timescale 1ns / 1ps

module proximity_stall_safety_monitor_test;
    import psm_pkg::*;

    localparam int HIST_DEPTH = 16;
    localparam int SETTLE_CYCLES = 2 * HIST_DEPTH + 8;
    localparam int LONG_HOLD = 400;
    localparam int LIMIT_CYCLES = 800000;
    localparam logic [1:0] MS_OTHER = 2'd0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_req i_in_data = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    proximity_stall_safety_monitor #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // register copies
    logic [15:0] warn_l = 16'd1000;
    logic [15:0] warn_r = 16'd1000;
    logic [15:0] crit_mm = 16'd300;
    logic [15:0] win_ms = 16'd3000;
    logic [7:0] chg_lim = 8'd5;
    logic [7:0] stall_lim = 8'd3;

    // monitor state copies
    logic [31:0] chg_time [HIST_DEPTH];
    logic chg_valid [HIST_DEPTH];
    int hist_slot = 0;
    logic obs_flag_q = 1'b0;
    logic [15:0] prev_speed = '0;
    logic [7:0] stall_cnt = '0;
    logic motor_on = 1'b0;
    logic [1:0] cur_status = ST_OK;

    t_req request_q[$];
    t_rsp verdict_q[$];
    logic req_taken = 1'b0;
    int mismatches = 0;
    logic [31:0] clock_ms = '0;
    int send_wait = 0;
    int send_quiet = 0;
    int recv_wait = 0;
    int recv_quiet = 0;
    logic long_hold_go = 1'b0;
    logic long_hold_done = 1'b0;

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            chg_time[i] = '0;
            chg_valid[i] = 1'b0;
        end
    end

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_rsp safety_verdict(input t_req rq);
        t_rsp rsp;
        logic swing;
        logic near_flag;
        logic [1:0] obs_st;
        logic [1:0] merged;
        logic [31:0] crit10;
        logic [31:0] warn10;
        logic [31:0] l10;
        logic [31:0] r10;
        logic [31:0] age;
        int recent;
        swing = (rq.machine_state == MS_SWINGING);
        rsp = '0;
        if (rq.kind == KIND_MOTOR) begin
            motor_on = rq.motor_running;
            if (rq.motor_running && prev_speed != 16'd0 && rq.motor_speed == 16'd0) begin
                if (stall_cnt != 8'hFF) stall_cnt = stall_cnt + 8'd1;
            end else if (rq.motor_speed != 16'd0) begin
                stall_cnt = '0;
            end
            prev_speed = rq.motor_speed;
        end else begin
            crit10 = swing ? crit_mm * 32'd9 : crit_mm * 32'd10;
            warn10 = swing ? warn_l * 32'd7 : warn_l * 32'd10;
            l10 = rq.left_distance_mm * 32'd10;
            r10 = rq.right_distance_mm * 32'd10;
            obs_st = ST_OK;
            if ((rq.left_distance_mm != 16'd0 && l10 < crit10) ||
                (rq.right_distance_mm != 16'd0 && r10 < crit10)) begin
                obs_st = ST_EMERGENCY;
            end else if ((l10 > crit10 && l10 < warn10) || (r10 > crit10 && r10 < warn10)) begin
                obs_st = ST_ERROR;
            end else begin
                near_flag = (rq.left_distance_mm != 16'd0 && rq.left_distance_mm < warn_l) ||
                            (rq.right_distance_mm != 16'd0 && rq.right_distance_mm < warn_r);
                if (near_flag != obs_flag_q) begin
                    // record the flag change, then count changes inside the window
                    obs_flag_q = near_flag;
                    chg_time[hist_slot] = rq.time_ms;
                    chg_valid[hist_slot] = 1'b1;
                    hist_slot = (hist_slot + 1) % HIST_DEPTH;
                    recent = 0;
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        age = rq.time_ms - chg_time[i];
                        if (chg_valid[i] && age < {16'h0, win_ms}) recent++;
                    end
                    if (recent > int'(chg_lim)) obs_st = ST_EMERGENCY;
                end
            end
            merged = obs_st;
            if (!rq.user_present && swing) merged = ST_EMERGENCY;
            if (motor_on && stall_cnt >= stall_lim) begin
                stall_cnt = '0;
                merged = ST_EMERGENCY;
            end
            if (merged != cur_status) begin
                if (merged == ST_EMERGENCY && rq.machine_state != MS_EMERGENCY) begin
                    rsp.raise_emergency = 1'b1;
                end else if (merged == ST_ERROR && rq.machine_state != MS_ERROR &&
                             rq.machine_state != MS_EMERGENCY) begin
                    rsp.raise_obstacle = 1'b1;
                end
                cur_status = merged;
            end
        end
        rsp.status = cur_status;
        return rsp;
    endfunction

    task automatic draw_gap(inout int quiet, output int gap);
        int pick;
        pick = int'($urandom_range(0, 99));
        if (quiet > 0) begin
            quiet--;
            gap = 0;
        end else if (pick < 3) begin
            quiet = int'($urandom_range(20, 80));
            gap = 0;
        end else if (pick < 55) begin
            gap = 0;
        end else if (pick < 92) begin
            gap = int'($urandom_range(1, 4));
        end else begin
            gap = int'($urandom_range(15, 60));
        end
    endtask

    task automatic flag_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): want st %0d emg %0b obs %0b, got st %0d emg %0b obs %0b",
                     what, want.status, want.raise_emergency, want.raise_obstacle,
                     got.status, got.raise_emergency, got.raise_obstacle);
        end
    endtask

    // acceptance, prediction and response checking
    always @(posedge i_clk) begin
        t_rsp want;
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        if (req_taken) verdict_q.push_back(safety_verdict(i_in_data));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                flag_mismatch("no request pending", '0, o_out_data);
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.raise_emergency !== want.raise_emergency ||
                    o_out_data.raise_obstacle !== want.raise_obstacle) begin
                    flag_mismatch("field", want, o_out_data);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (send_wait > 0) begin
                i_in_valid <= 1'b0;
                send_wait--;
            end else if (request_q.size() > 0) begin
                i_in_data <= request_q.pop_front();
                i_in_valid <= 1'b1;
                draw_gap(send_quiet, send_wait);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // response side back-pressure, with one long hold-off
    always @(negedge i_clk) begin
        if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            recv_wait = LONG_HOLD;
        end
        if (recv_wait > 0) begin
            i_out_ready <= 1'b0;
            recv_wait--;
        end else begin
            i_out_ready <= 1'b1;
            draw_gap(recv_quiet, recv_wait);
        end
    end

    initial begin
        for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge i_clk);
        $display("[proximity_stall_safety_monitor] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LEFT_WARNING: warn_l = val;
            CFG_RIGHT_WARNING: warn_r = val;
            CFG_CRITICAL: crit_mm = val;
            CFG_CHANGE_WINDOW: win_ms = val;
            CFG_CHANGE_LIMIT: chg_lim = val[7:0];
            CFG_STALL_LIMIT: stall_lim = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] l, input logic [15:0] r, input logic [15:0] c,
                                input logic [15:0] w, input logic [7:0] cl, input logic [7:0] sl);
        write_reg(CFG_LEFT_WARNING, l);
        write_reg(CFG_RIGHT_WARNING, r);
        write_reg(CFG_CRITICAL, c);
        write_reg(CFG_CHANGE_WINDOW, w);
        write_reg(CFG_CHANGE_LIMIT, {8'h0, cl});
        write_reg(CFG_STALL_LIMIT, {8'h0, sl});
    endtask

    task automatic random_config();
        apply_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                     16'($urandom_range(0, 1500)), 16'($urandom_range(1, 5000)),
                     8'($urandom_range(0, 8)), 8'($urandom_range(0, 3)));
    endtask

    // wait for all requests to drain and the block to go quiet
    task automatic settle();
        while (request_q.size() != 0 || i_in_valid || verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_check(input logic [31:0] t, input logic [15:0] l, input logic [15:0] r,
                             input logic [1:0] ms, input logic present);
        t_req rq;
        rq = '0;
        rq.kind = KIND_CHECK;
        rq.time_ms = t;
        rq.left_distance_mm = l;
        rq.right_distance_mm = r;
        rq.machine_state = ms;
        rq.user_present = present;
        request_q.push_back(rq);
    endtask

    task automatic add_motor(input logic run, input logic [15:0] speed);
        t_req rq;
        rq = '0;
        rq.kind = KIND_MOTOR;
        rq.motor_running = run;
        rq.motor_speed = speed;
        request_q.push_back(rq);
    endtask

    // distances clustered around the current thresholds
    function automatic logic [15:0] pick_distance();
        int pick;
        int base;
        int offset;
        int val;
        pick = int'($urandom_range(0, 99));
        offset = int'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
            0: base = int'(crit_mm);
            1: base = int'(crit_mm) * 9 / 10;
            2: base = int'(warn_l);
            3: base = int'(warn_l) * 7 / 10;
            4: base = int'(warn_r);
            default: base = int'(warn_l) * 2;
        endcase
        val = base + offset - 2;
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        if (pick < 10) val = 0;
        else if (pick < 20) val = int'($urandom_range(0, 65535));
        return val[15:0];
    endfunction

    task automatic run_random(input int count);
        t_req rq;
        int pick;
        for (int n = 0; n < count; n++) begin
            rq.kind = ($urandom_range(0, 99) < 30) ? KIND_MOTOR : KIND_CHECK;
            rq.motor_running = ($urandom_range(0, 9) < 8);
            pick = int'($urandom_range(0, 9));
            if (pick < 4) rq.motor_speed = '0;
            else if (pick < 8) rq.motor_speed = 16'($urandom_range(1, 300));
            else rq.motor_speed = 16'($urandom_range(0, 65535));
            pick = int'($urandom_range(0, 99));
            if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 400);
            else if (pick < 97) clock_ms = clock_ms + $urandom_range(0, 20000);
            else clock_ms = $urandom;
            rq.time_ms = clock_ms;
            rq.left_distance_mm = pick_distance();
            rq.right_distance_mm = pick_distance();
            rq.machine_state = ($urandom_range(0, 9) < 4) ? MS_SWINGING
                                                          : 2'($urandom_range(0, 3));
            rq.user_present = ($urandom_range(0, 99) < 85);
            request_q.push_back(rq);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests under the reset register values
        add_motor(1'b1, 16'd100);
        add_motor(1'b1, 16'd0);
        add_check(32'd0, 16'd0, 16'd0, MS_OTHER, 1'b1);
        add_check(32'd10, 16'd299, 16'd0, MS_OTHER, 1'b1);
        add_check(32'd20, 16'd300, 16'd0, MS_EMERGENCY, 1'b1);
        add_check(32'd30, 16'd500, 16'd0, MS_OTHER, 1'b1);
        add_check(32'd40, 16'd2000, 16'd0, MS_OTHER, 1'b1);
        add_check(32'd50, 16'd500, 16'd0, MS_ERROR, 1'b1);
        add_check(32'd60, 16'hFFFF, 16'hFFFF, MS_OTHER, 1'b1);
        add_check(32'd70, 16'd0, 16'd299, MS_EMERGENCY, 1'b1);
        add_check(32'd80, 16'd269, 16'd0, MS_SWINGING, 1'b1);
        add_check(32'd90, 16'd270, 16'd0, MS_SWINGING, 1'b1);
        add_check(32'd100, 16'd699, 16'd0, MS_SWINGING, 1'b1);
        add_check(32'd110, 16'd700, 16'd0, MS_SWINGING, 1'b0);
        // rapid obstacle flag toggling
        for (int k = 0; k < 7; k++) begin
            add_check(32'd200 + 32'(k * 50), (k % 2) ? 16'd2000 : 16'd300, 16'd0,
                      MS_OTHER, 1'b1);
        end
        // timestamp wrap inside the window
        add_check(32'hFFFF_FFF0, 16'd300, 16'd0, MS_OTHER, 1'b1);
        add_check(32'h0000_0010, 16'd2000, 16'd0, MS_OTHER, 1'b1);
        add_motor(1'b0, 16'hFFFF);
        add_check(32'd400, 16'd0, 16'd0, MS_OTHER, 1'b1);

        settle();
        random_config();
        run_random(160);
        long_hold_go = 1'b1;

        settle();
        apply_config(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        run_random(140);

        settle();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        run_random(140);

        settle();
        apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(140);

        // stall limit of one, right warning above left, tight change window
        settle();
        apply_config(16'd800, 16'd1500, 16'd200, 16'($urandom_range(200, 1500)),
                     8'($urandom_range(0, 2)), 8'd1);
        run_random(190);

        settle();
        random_config();
        run_random(180);

        settle();
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("[proximity_stall_safety_monitor] OK");
        end else begin
            $display("[proximity_stall_safety_monitor] ERROR");
        end
        $finish;
    end

endmodule
